// File: hdl/battlvl_pkg.sv
// ----------------------------------------------------------------------------
// battlvl_pkg
// Shared widths, register indexes, reset values and helpers for the battery
// level indicator.
// ----------------------------------------------------------------------------
package battlvl_pkg;

   // field widths
   localparam int SampleWidth = 12;
   localparam int FilterWidth = 16;
   localparam int CountWidth  = 6;
   localparam int LedWidth    = 4;
   localparam int LevelWidth  = 2;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 16;

   // stream widths (padded to whole bytes)
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 24;

   // register indexes
   typedef enum logic [CsrAddrWidth-1:0] {
      REG_INIT_UPDATES     = 2'd0,
      REG_THRESH_VERY_HIGH = 2'd1,
      REG_THRESH_HIGH      = 2'd2,
      REG_THRESH_MID       = 2'd3
   } csr_index_type;

   // battery level codes
   typedef enum logic [LevelWidth-1:0] {
      LEVEL_VERY_HIGH = 2'd0,
      LEVEL_HIGH      = 2'd1,
      LEVEL_MID       = 2'd2,
      LEVEL_LOW       = 2'd3
   } level_type;

   // register reset values
   localparam logic [CountWidth-1:0]  InitUpdatesReset    = 6'd50;
   localparam logic [FilterWidth-1:0] ThreshVeryHighReset = 16'd55488;
   localparam logic [FilterWidth-1:0] ThreshHighReset     = 16'd51326;
   localparam logic [FilterWidth-1:0] ThreshMidReset      = 16'd47164;

   localparam logic [LedWidth-1:0] LedsAllOn = 4'hF;

   // bar pattern shown for each level after start-up
   function automatic logic [LedWidth-1:0] bar_pattern(input level_type lvl);
      logic [LedWidth-1:0] leds;
      unique case (lvl)
         LEVEL_VERY_HIGH: leds = 4'h0;
         LEVEL_HIGH:      leds = 4'h1;
         LEVEL_MID:       leds = 4'h3;
         LEVEL_LOW:       leds = 4'h7;
         default:         leds = 4'h7;
      endcase
      return leds;
   endfunction

endpackage

// File: hdl/battery_level_indicator.sv
// ----------------------------------------------------------------------------
// battery_level_indicator
// Averages four ADC samples per item, low-pass filters the level, classifies
// it against three thresholds and drives a four-LED bar.
// ----------------------------------------------------------------------------
// path: an accepted item goes through the input reg, then the result reg
// throughput: one item per cycle while the result is not stalled; the filter update is one add between regs
// a stalled result holds the result reg and, one item later, the input reg
// reset: synchronous, active high; clears the filter to zero, enters
// start-up with count zero and loads the register defaults
module battery_level_indicator
   import battlvl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   // configuration write port
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,

   // update items
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // sample_a [11:0], sample_b [23:12], sample_c [35:24], sample_d [47:36]
   input  logic [ReqDataWidth-1:0] req_tdata,

   // result items
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // led_pins [3:0], level [5:4], filtered_level [21:6], zero [23:22]
   output logic [RspDataWidth-1:0] rsp_tdata,
   // in_startup [0]
   output logic                    rsp_tuser
);

   // configuration registers
   logic [CountWidth-1:0]  init_updates_ff;
   logic [FilterWidth-1:0] thresh_very_high_ff;
   logic [FilterWidth-1:0] thresh_high_ff;
   logic [FilterWidth-1:0] thresh_mid_ff;

   // block state
   logic [FilterWidth-1:0] filter_ff, filter_in;
   logic                   startup_ff, startup_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   // input stage
   logic                   in_valid_ff;
   logic [ReqDataWidth-1:0] in_data_ff;

   // result stage
   logic                   out_valid_ff;
   logic [LedWidth-1:0]    out_leds_ff, out_leds_in;
   level_type              out_level_ff, out_level_in;
   logic                   out_startup_ff;
   logic [FilterWidth-1:0] out_filter_ff;

   logic                   advance;
   logic [SampleWidth+1:0] sample_sum;
   logic [SampleWidth-1:0] sample_avg;
   logic [FilterWidth:0]   filter_sum;

   // stage moves when the result reg is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_updates_ff     <= InitUpdatesReset;
         thresh_very_high_ff <= ThreshVeryHighReset;
         thresh_high_ff      <= ThreshHighReset;
         thresh_mid_ff       <= ThreshMidReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            REG_INIT_UPDATES:     init_updates_ff     <= csr_wdata[CountWidth-1:0];
            REG_THRESH_VERY_HIGH: thresh_very_high_ff <= csr_wdata;
            REG_THRESH_HIGH:      thresh_high_ff      <= csr_wdata;
            REG_THRESH_MID:       thresh_mid_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   // average, filter, classify and start-up bookkeeping
   always_comb begin
      sample_sum = {2'b00, in_data_ff[11:0]}  + {2'b00, in_data_ff[23:12]}
                 + {2'b00, in_data_ff[35:24]} + {2'b00, in_data_ff[47:36]};
      sample_avg = sample_sum[SampleWidth+1:2];
      filter_sum = {1'b0, sample_avg, 4'b0000} + {1'b0, filter_ff};
      filter_in  = filter_sum[FilterWidth:1];

      if (filter_in > thresh_very_high_ff) begin
         out_level_in = LEVEL_VERY_HIGH;
      end else if (filter_in > thresh_high_ff) begin
         out_level_in = LEVEL_HIGH;
      end else if (filter_in > thresh_mid_ff) begin
         out_level_in = LEVEL_MID;
      end else begin
         out_level_in = LEVEL_LOW;
      end

      count_in   = count_ff;
      startup_in = startup_ff;
      if (startup_ff) begin
         out_leds_in = LedsAllOn;
         count_in    = count_ff + CountWidth'(1);
         if (count_in == init_updates_ff) begin
            startup_in = 1'b0;
         end
      end else begin
         out_leds_in = bar_pattern(out_level_in);
      end
   end

   // state update, one per item
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff  <= '0;
         startup_ff <= 1'b1;
         count_ff   <= '0;
      end else if (advance) begin
         filter_ff  <= filter_in;
         startup_ff <= startup_in;
         count_ff   <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_leds_ff    <= out_leds_in;
         out_level_ff   <= out_level_in;
         out_startup_ff <= startup_ff;
         out_filter_ff  <= filter_in;
      end
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_filter_ff, out_level_ff, out_leds_ff};
   assign rsp_tuser  = out_startup_ff;

endmodule
